[hw/rtl/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants and types of the limit switch conditioner.
// ----------------------------------------------------------------------------
package lsc_pkg;

   // Number of filtered limit switches and default filter run length
   localparam int LSC_SWITCH_COUNT = 10;
   localparam int LSC_FILTER_RUN   = 2;

   // Ready flag sets once this many ticks have gone by
   localparam logic [2:0] LSC_READY_TICKS = 3'd4;

   // Field widths
   localparam int LSC_COUNT_WIDTH  = 12;
   localparam int LSC_STEP_WIDTH   = 10;
   localparam int LSC_CSR_WIDTH    = 12;
   localparam int LSC_CSR_IDX_WIDTH = 2;

   // Register indexes of the configuration port
   localparam logic [LSC_CSR_IDX_WIDTH-1:0] LSC_CSR_TOP_RELOAD   = 2'd0;
   localparam logic [LSC_CSR_IDX_WIDTH-1:0] LSC_CSR_LIMIT_LEVEL  = 2'd1;
   localparam logic [LSC_CSR_IDX_WIDTH-1:0] LSC_CSR_WALK_CEILING = 2'd2;

   // Register reset values
   localparam logic [LSC_STEP_WIDTH-1:0]  LSC_TOP_RELOAD_RESET   = 10'd0;
   localparam logic                       LSC_LIMIT_LEVEL_RESET  = 1'b1;
   localparam logic [LSC_COUNT_WIDTH-1:0] LSC_WALK_CEILING_RESET = 12'd2000;

   // Knead width codes
   localparam logic [1:0] LSC_WIDTH_UNKNOWN = 2'd0;
   localparam logic [1:0] LSC_WIDTH_MIN     = 2'd1;
   localparam logic [1:0] LSC_WIDTH_MED     = 2'd2;
   localparam logic [1:0] LSC_WIDTH_MAX     = 2'd3;

   // Switch positions in the filtered vector used by the walk counter
   localparam int LSC_SW_WALK_UP   = 6;
   localparam int LSC_SW_WALK_DOWN = 7;

   // Configuration register set
   typedef struct packed {
      logic [LSC_STEP_WIDTH-1:0]  top_reload_position;
      logic                       limit_active_level;
      logic [LSC_COUNT_WIDTH-1:0] walk_count_ceiling;
   } lsc_csr_type;

   // Per-tick controls of the walk counter
   typedef struct packed {
      logic enable;
      logic pulse_level;
      logic going_up;
      logic walk_up_flag;
      logic walk_down_flag;
   } lsc_walk_ctrl_type;

endpackage

[hw/rtl/lsc_channels.sv]
// ----------------------------------------------------------------------------
// lsc channels
// Valid/ready channels for tick items and conditioned results.
// ----------------------------------------------------------------------------
interface lsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] signal_3d;
   logic [7:0] board_byte_one;
   logic [7:0] board_byte_two;
   logic [7:0] board_byte_three;
   logic       walk_pulse_level;
   logic       walk_going_up;

   modport source (
      output valid, signal_3d, board_byte_one, board_byte_two, board_byte_three,
             walk_pulse_level, walk_going_up,
      input  ready
   );
   modport sink (
      input  valid, signal_3d, board_byte_one, board_byte_two, board_byte_three,
             walk_pulse_level, walk_going_up,
      output ready
   );
endinterface

interface lsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  filtered_switches;
   logic [2:0]  direct_switches;
   logic [1:0]  knead_width;
   logic        shoulder_touched;
   logic        front_switch_3d;
   logic        back_switch_3d;
   logic [11:0] walk_count;
   logic [9:0]  walk_step_position;
   logic        input_ready;

   modport source (
      output valid, filtered_switches, direct_switches, knead_width, shoulder_touched,
             front_switch_3d, back_switch_3d, walk_count, walk_step_position,
             input_ready,
      input  ready
   );
   modport sink (
      input  valid, filtered_switches, direct_switches, knead_width, shoulder_touched,
             front_switch_3d, back_switch_3d, walk_count, walk_step_position,
             input_ready,
      output ready
   );
endinterface

[hw/rtl/lsc_run_filter.sv]
// ----------------------------------------------------------------------------
// lsc_run_filter
// Run filter of one switch: the flag sets after FILTER_RUN high samples in a
// row and clears after FILTER_RUN low samples in a row.
// ----------------------------------------------------------------------------
module lsc_run_filter #(
   parameter int FILTER_RUN = lsc_pkg::LSC_FILTER_RUN
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic level,
   output logic flag_in
);
   import lsc_pkg::*;

   localparam int RunWidth = $clog2(FILTER_RUN + 1);
   localparam logic [RunWidth-1:0] RunMax = RunWidth'(FILTER_RUN);

   logic [RunWidth-1:0] high_run_ff, high_run_in;
   logic [RunWidth-1:0] low_run_ff, low_run_in;
   logic                flag_ff;

   // Advance the run of the sampled level, restart the other one
   always_comb begin
      high_run_in = high_run_ff;
      low_run_in  = low_run_ff;
      flag_in     = flag_ff;
      if (level) begin
         low_run_in  = '0;
         high_run_in = (high_run_ff < RunMax) ? high_run_ff + 1'b1 : RunMax;
         if (high_run_in == RunMax) flag_in = 1'b1;
      end else begin
         high_run_in = '0;
         low_run_in  = (low_run_ff < RunMax) ? low_run_ff + 1'b1 : RunMax;
         if (low_run_in == RunMax) flag_in = 1'b0;
      end
   end

   // Hold state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_run_ff <= '0;
         low_run_ff  <= '0;
         flag_ff     <= 1'b0;
      end else if (enable) begin
         high_run_ff <= high_run_in;
         low_run_ff  <= low_run_in;
         flag_ff     <= flag_in;
      end
   end

endmodule

[hw/rtl/lsc_walk_counter.sv]
// ----------------------------------------------------------------------------
// lsc_walk_counter
// Walk pulse edge counter with saturation at zero and at the ceiling, and
// reload when a walk limit switch is reached.
// ----------------------------------------------------------------------------
module lsc_walk_counter (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lsc_pkg::lsc_csr_type                     csr,
   input  lsc_pkg::lsc_walk_ctrl_type               ctrl,
   output logic [lsc_pkg::LSC_COUNT_WIDTH-1:0]      count_in
);
   import lsc_pkg::*;

   logic                       last_level_ff;
   logic [LSC_COUNT_WIDTH-1:0] count_ff;
   logic                       pulse_edge;

   assign pulse_edge = ctrl.pulse_level != last_level_ff;

   // Step the count on a pulse edge, then apply the limit reload
   always_comb begin
      count_in = count_ff;
      if (pulse_edge) begin
         if (ctrl.going_up) begin
            if (count_ff < csr.walk_count_ceiling) count_in = count_ff + 1'b1;
            if (ctrl.walk_up_flag == csr.limit_active_level) begin
               count_in = {csr.top_reload_position, 2'b00};
            end
         end else begin
            if (count_ff != '0) count_in = count_ff - 1'b1;
            if (ctrl.walk_down_flag == csr.limit_active_level) count_in = '0;
         end
      end
   end

   // Hold count and last pulse level between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         count_ff      <= '0;
      end else if (ctrl.enable) begin
         last_level_ff <= ctrl.pulse_level;
         count_ff      <= count_in;
      end
   end

endmodule

[hw/rtl/limit_switch_conditioner.sv]
// ----------------------------------------------------------------------------
// limit_switch_conditioner
// Conditions the limit switches of a chair and counts its walk pulses.
// ----------------------------------------------------------------------------
// Each transfer on req is one 5 ms tick. The tick updates the switch filters,
// knead width latch, walk count and ready flag in the cycle it is taken, and
// its result appears on rsp in the next cycle from the result register. One
// tick is taken every cycle as long as the result register is free or is
// being emptied in the same cycle; a stalled rsp holds req off. Configuration
// writes on the csr port take effect at the next tick.
module limit_switch_conditioner #(
   parameter int FILTER_RUN = lsc_pkg::LSC_FILTER_RUN
) (
   input  logic                                   clock,
   input  logic                                   reset,
   lsc_req_if.sink                                req_if,
   lsc_rsp_if.source                              rsp_if,
   input  logic                                   csr_write_enable,
   input  logic [lsc_pkg::LSC_CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [lsc_pkg::LSC_CSR_WIDTH-1:0]      csr_write_data
);
   import lsc_pkg::*;

   lsc_csr_type                 csr_ff;
   logic                        accept;
   logic [LSC_SWITCH_COUNT-1:0] raw_switches;
   logic [LSC_SWITCH_COUNT-1:0] flags_in;
   lsc_walk_ctrl_type           walk_ctrl;
   logic [LSC_COUNT_WIDTH-1:0]  count_in;
   logic [2:0]                  tick_tally_ff, tick_tally_in;
   logic                        ready_flag_ff, ready_flag_in;
   logic [1:0]                  width_ff, width_in;
   logic                        rsp_valid_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.top_reload_position <= LSC_TOP_RELOAD_RESET;
         csr_ff.limit_active_level  <= LSC_LIMIT_LEVEL_RESET;
         csr_ff.walk_count_ceiling  <= LSC_WALK_CEILING_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            LSC_CSR_TOP_RELOAD: begin
               csr_ff.top_reload_position <= csr_write_data[LSC_STEP_WIDTH-1:0];
            end
            LSC_CSR_LIMIT_LEVEL: begin
               csr_ff.limit_active_level <= csr_write_data[0];
            end
            LSC_CSR_WALK_CEILING: begin
               csr_ff.walk_count_ceiling <= csr_write_data[LSC_COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Take a tick whenever the result register is free or drains this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // Gather raw switch levels, flex switches are active low
   assign raw_switches = {
      ~req_if.board_byte_three[0],   // flex out
      ~req_if.board_byte_three[1],   // flex in
      req_if.board_byte_two[0],      // walk down
      req_if.board_byte_two[1],      // walk up
      req_if.board_byte_two[6],      // slide down
      req_if.board_byte_two[7],      // slide up
      req_if.board_byte_one[7:4]     // back down, back up, leg down, leg up
   };

   // Filter each switch
   for (genvar i = 0; i < LSC_SWITCH_COUNT; i++) begin : g_filter
      lsc_run_filter #(
         .FILTER_RUN (FILTER_RUN)
      ) u_filter (
         .clock   (clock),
         .reset   (reset),
         .enable  (accept),
         .level   (raw_switches[i]),
         .flag_in (flags_in[i])
      );
   end

   // Walk pulse counter sees this tick's filtered limit flags
   assign walk_ctrl.enable         = accept;
   assign walk_ctrl.pulse_level    = req_if.walk_pulse_level;
   assign walk_ctrl.going_up       = req_if.walk_going_up;
   assign walk_ctrl.walk_up_flag   = flags_in[LSC_SW_WALK_UP];
   assign walk_ctrl.walk_down_flag = flags_in[LSC_SW_WALK_DOWN];

   lsc_walk_counter u_walk (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .ctrl     (walk_ctrl),
      .count_in (count_in)
   );

   // Count ticks up to the ready point, keep ready sticky
   always_comb begin
      tick_tally_in = (tick_tally_ff < LSC_READY_TICKS) ? tick_tally_ff + 1'b1
                                                        : tick_tally_ff;
      ready_flag_in = ready_flag_ff || (tick_tally_in == LSC_READY_TICKS);
   end

   // Latch knead width, max over med over min
   always_comb begin
      width_in = width_ff;
      if (req_if.signal_3d[0])      width_in = LSC_WIDTH_MAX;
      else if (req_if.signal_3d[1]) width_in = LSC_WIDTH_MED;
      else if (req_if.signal_3d[2]) width_in = LSC_WIDTH_MIN;
   end

   // Tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_tally_ff <= '0;
         ready_flag_ff <= 1'b0;
         width_ff      <= LSC_WIDTH_UNKNOWN;
      end else if (accept) begin
         tick_tally_ff <= tick_tally_in;
         ready_flag_ff <= ready_flag_in;
         width_ff      <= width_in;
      end
   end

   // Result register: load on transfer in, drop valid on transfer out
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_if.filtered_switches  <= flags_in;
         rsp_if.direct_switches    <= {~req_if.board_byte_two[4],
                                       ~req_if.board_byte_two[5],
                                       ~req_if.board_byte_two[3]};
         rsp_if.knead_width        <= width_in;
         rsp_if.shoulder_touched   <= req_if.signal_3d[4];
         rsp_if.front_switch_3d    <= req_if.signal_3d[6];
         rsp_if.back_switch_3d     <= req_if.signal_3d[5];
         rsp_if.walk_count         <= count_in;
         rsp_if.walk_step_position <= count_in[LSC_COUNT_WIDTH-1:2];
         rsp_if.input_ready        <= ready_flag_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;

   // Checks
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick did not produce a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("input taken while a result is stalled");

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      ready_flag_ff |=> ready_flag_ff)
      else $error("ready flag cleared without reset");

   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      tick_tally_ff <= LSC_READY_TICKS)
      else $error("tick tally beyond ready point");

   a_ready_follows_tally: assert property (@(posedge clock) disable iff (reset)
      ready_flag_ff == (tick_tally_ff == LSC_READY_TICKS))
      else $error("ready flag out of step with tick tally");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit switch conditioner testbench
// Sends 5 ms ticks through the conditioner under random idling and result
// stalls, predicts each result from the tick stream and the register
// settings, and checks every result field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import lsc_pkg::*;

   typedef struct packed {
      logic [7:0] signal_3d;
      logic [7:0] board_byte_one;
      logic [7:0] board_byte_two;
      logic [7:0] board_byte_three;
      logic       walk_pulse_level;
      logic       walk_going_up;
   } tick_type;

   typedef struct packed {
      logic [9:0]  filtered_switches;
      logic [2:0]  direct_switches;
      logic [1:0]  knead_width;
      logic        shoulder_touched;
      logic        front_switch_3d;
      logic        back_switch_3d;
      logic [11:0] walk_count;
      logic [9:0]  walk_step_position;
      logic        input_ready;
   } result_type;

   localparam logic [1:0] RUN_LIMIT = 2'(LSC_FILTER_RUN);

   // Tracks the conditioner state and holds the results still owed by the block
   class switch_scoreboard;
      logic [LSC_STEP_WIDTH-1:0]   top_reload;
      logic                        limit_level;
      logic [LSC_COUNT_WIDTH-1:0]  ceiling;
      logic [1:0]                  high_run [LSC_SWITCH_COUNT];
      logic [1:0]                  low_run  [LSC_SWITCH_COUNT];
      logic [LSC_SWITCH_COUNT-1:0] flags;
      logic [1:0]                  width;
      logic                        last_level;
      logic [LSC_COUNT_WIDTH-1:0]  count;
      logic [2:0]                  tally;
      logic                        ready;
      result_type                  expected_results[$];
      int unsigned                 errors, checked, reloads, ceiling_hits;

      function new();
         top_reload   = LSC_TOP_RELOAD_RESET;
         limit_level  = LSC_LIMIT_LEVEL_RESET;
         ceiling      = LSC_WALK_CEILING_RESET;
         foreach (high_run[i]) begin
            high_run[i] = '0;
            low_run[i]  = '0;
         end
         flags        = '0;
         width        = LSC_WIDTH_UNKNOWN;
         last_level   = 1'b0;
         count        = '0;
         tally        = '0;
         ready        = 1'b0;
         errors       = 0;
         checked      = 0;
         reloads      = 0;
         ceiling_hits = 0;
      endfunction

      function void write_register(logic [LSC_CSR_IDX_WIDTH-1:0] idx,
                                   logic [LSC_CSR_WIDTH-1:0] data);
         case (idx)
            LSC_CSR_TOP_RELOAD:   top_reload  = data[LSC_STEP_WIDTH-1:0];
            LSC_CSR_LIMIT_LEVEL:  limit_level = data[0];
            LSC_CSR_WALK_CEILING: ceiling     = data[LSC_COUNT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // Advance the state by one accepted tick and queue its result
      function void note_tick(tick_type t);
         logic [LSC_SWITCH_COUNT-1:0] raw;
         result_type r;
         if (tally < LSC_READY_TICKS) tally++;
         if (tally >= LSC_READY_TICKS) ready = 1'b1;

         // later knead bits win: max over med over min
         if (t.signal_3d[2]) width = LSC_WIDTH_MIN;
         if (t.signal_3d[1]) width = LSC_WIDTH_MED;
         if (t.signal_3d[0]) width = LSC_WIDTH_MAX;

         raw = {~t.board_byte_three[0], ~t.board_byte_three[1],
                t.board_byte_two[0], t.board_byte_two[1],
                t.board_byte_two[6], t.board_byte_two[7],
                t.board_byte_one[7:4]};

         // run filters: set after a run of highs, clear after a run of lows
         for (int i = 0; i < LSC_SWITCH_COUNT; i++) begin
            if (raw[i]) begin
               low_run[i] = '0;
               if (high_run[i] < RUN_LIMIT) high_run[i]++;
               if (high_run[i] >= RUN_LIMIT) begin
                  high_run[i] = RUN_LIMIT;
                  flags[i] = 1'b1;
               end
            end else begin
               high_run[i] = '0;
               if (low_run[i] < RUN_LIMIT) low_run[i]++;
               if (low_run[i] >= RUN_LIMIT) begin
                  low_run[i] = RUN_LIMIT;
                  flags[i] = 1'b0;
               end
            end
         end

         // walk pulse edge, limit test sees this tick's flags
         if (t.walk_pulse_level != last_level) begin
            if (t.walk_going_up) begin
               if (count < ceiling) count++;
               else ceiling_hits++;
               if (flags[LSC_SW_WALK_UP] == limit_level) begin
                  count = {top_reload, 2'b00};
                  reloads++;
               end
            end else begin
               if (count != '0) count--;
               if (flags[LSC_SW_WALK_DOWN] == limit_level) begin
                  count = '0;
                  reloads++;
               end
            end
         end
         last_level = t.walk_pulse_level;

         r.filtered_switches  = flags;
         r.direct_switches    = {~t.board_byte_two[4], ~t.board_byte_two[5],
                                 ~t.board_byte_two[3]};
         r.knead_width        = width;
         r.shoulder_touched   = t.signal_3d[4];
         r.front_switch_3d    = t.signal_3d[6];
         r.back_switch_3d     = t.signal_3d[5];
         r.walk_count         = count;
         r.walk_step_position = count[LSC_COUNT_WIDTH-1:2];
         r.input_ready        = ready;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      // Match one result against the oldest owed one
      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result with no tick owed, expected none actual count %0h",
                     $time, got.walk_count);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         checked++;
         compare_field("filtered_switches", want.filtered_switches, got.filtered_switches);
         compare_field("direct_switches", want.direct_switches, got.direct_switches);
         compare_field("knead_width", want.knead_width, got.knead_width);
         compare_field("shoulder_touched", want.shoulder_touched, got.shoulder_touched);
         compare_field("front_switch_3d", want.front_switch_3d, got.front_switch_3d);
         compare_field("back_switch_3d", want.back_switch_3d, got.back_switch_3d);
         compare_field("walk_count", want.walk_count, got.walk_count);
         compare_field("walk_step_position", want.walk_step_position,
                       got.walk_step_position);
         compare_field("input_ready", want.input_ready, got.input_ready);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                         csr_write_enable;
   logic [LSC_CSR_IDX_WIDTH-1:0] csr_index;
   logic [LSC_CSR_WIDTH-1:0]     csr_write_data;

   lsc_req_if req_if();
   lsc_rsp_if rsp_if();

   limit_switch_conditioner uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   switch_scoreboard board = new();

   bit          idle_on;
   int unsigned stall_left;
   int unsigned sent_ticks;
   int unsigned settings_used;
   result_type  seen_result;

   // Tick generator state: held bytes and slow walk switch levels
   logic       limit_setting;
   logic       walk_up_raw, walk_down_raw, pulse_level, going_up;
   logic [7:0] held_3d, held_one, held_two, held_three;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check each result transfer and stall the result side in bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen_result.filtered_switches  = rsp_if.filtered_switches;
            seen_result.direct_switches    = rsp_if.direct_switches;
            seen_result.knead_width        = rsp_if.knead_width;
            seen_result.shoulder_touched   = rsp_if.shoulder_touched;
            seen_result.front_switch_3d    = rsp_if.front_switch_3d;
            seen_result.back_switch_3d     = rsp_if.back_switch_3d;
            seen_result.walk_count         = rsp_if.walk_count;
            seen_result.walk_step_position = rsp_if.walk_step_position;
            seen_result.input_ready        = rsp_if.input_ready;
            board.check_result(seen_result);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= (stall_left == 0);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Offer one tick, idling first now and then, and hold it until transfer
   task automatic send_tick(input tick_type t);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.signal_3d        <= t.signal_3d;
      req_if.board_byte_one   <= t.board_byte_one;
      req_if.board_byte_two   <= t.board_byte_two;
      req_if.board_byte_three <= t.board_byte_three;
      req_if.walk_pulse_level <= t.walk_pulse_level;
      req_if.walk_going_up    <= t.walk_going_up;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_tick(t);
      sent_ticks++;
   endtask

   task automatic send_fields(input logic [7:0] s3d, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic lvl, input logic up);
      send_tick('{s3d, b1, b2, b3, lvl, up});
   endtask

   // Drain all owed results, then load the three registers back to back
   task automatic apply_settings(input logic [LSC_STEP_WIDTH-1:0] reload,
                                 input logic level,
                                 input logic [LSC_COUNT_WIDTH-1:0] ceil);
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= LSC_CSR_TOP_RELOAD;
      csr_write_data   <= {2'b00, reload};
      @(posedge clock);
      board.write_register(LSC_CSR_TOP_RELOAD, {2'b00, reload});
      csr_index        <= LSC_CSR_LIMIT_LEVEL;
      csr_write_data   <= {11'd0, level};
      @(posedge clock);
      board.write_register(LSC_CSR_LIMIT_LEVEL, {11'd0, level});
      csr_index        <= LSC_CSR_WALK_CEILING;
      csr_write_data   <= ceil;
      @(posedge clock);
      board.write_register(LSC_CSR_WALK_CEILING, ceil);
      csr_write_enable <= 1'b0;
      limit_setting = level;
      settings_used++;
   endtask

   // Mostly steady switches with toggling walk pulses, some pure noise
   function automatic tick_type next_random_tick();
      tick_type t;
      if ($urandom_range(0, 15) == 0) begin
         t.signal_3d        = 8'($urandom_range(0, 255));
         t.board_byte_one   = 8'($urandom_range(0, 255));
         t.board_byte_two   = 8'($urandom_range(0, 255));
         t.board_byte_three = 8'($urandom_range(0, 255));
         t.walk_pulse_level = 1'($urandom_range(0, 1));
         t.walk_going_up    = 1'($urandom_range(0, 1));
         return t;
      end
      if ($urandom_range(0, 3) == 0) begin
         held_3d = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 0) held_3d[2:0] = 3'b000;
      end
      if ($urandom_range(0, 3) == 0) held_one   = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) held_two   = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) held_three = 8'($urandom_range(0, 255));
      // keep walk limits mostly released so the count can travel
      if (walk_up_raw == limit_setting) begin
         if ($urandom_range(0, 2) == 0) walk_up_raw = ~walk_up_raw;
      end else if ($urandom_range(0, 19) == 0) begin
         walk_up_raw = ~walk_up_raw;
      end
      if (walk_down_raw == limit_setting) begin
         if ($urandom_range(0, 2) == 0) walk_down_raw = ~walk_down_raw;
      end else if ($urandom_range(0, 19) == 0) begin
         walk_down_raw = ~walk_down_raw;
      end
      if ($urandom_range(0, 3) != 0) pulse_level = ~pulse_level;
      if ($urandom_range(0, 15) == 0) going_up = ~going_up;
      t = '{held_3d, held_one, {held_two[7:2], walk_up_raw, walk_down_raw},
            held_three, pulse_level, going_up};
      return t;
   endfunction

   initial begin
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = LSC_CSR_TOP_RELOAD;
      csr_write_data          = '0;
      req_if.valid            = 1'b0;
      req_if.signal_3d        = '0;
      req_if.board_byte_one   = '0;
      req_if.board_byte_two   = '0;
      req_if.board_byte_three = '0;
      req_if.walk_pulse_level = 1'b0;
      req_if.walk_going_up    = 1'b0;
      rsp_if.ready            = 1'b0;
      idle_on                 = 1'b1;
      stall_left              = 0;
      sent_ticks              = 0;
      settings_used           = 1;
      limit_setting           = LSC_LIMIT_LEVEL_RESET;
      walk_up_raw             = 1'b0;
      walk_down_raw           = 1'b0;
      pulse_level             = 1'b1;
      going_up                = 1'b1;
      held_3d                 = '0;
      held_one                = '0;
      held_two                = '0;
      held_three              = 8'hFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes, knead priority, reloads, floor at zero
      send_fields(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_fields(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
      send_fields(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
      send_fields(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      send_fields(8'h04, 8'h0F, 8'h00, 8'hFF, 1'b1, 1'b0);
      send_fields(8'h06, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1);
      send_fields(8'h05, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1);
      send_fields(8'h70, 8'hF0, 8'hC0, 8'hFC, 1'b0, 1'b1);
      send_fields(8'h08, 8'h00, 8'h38, 8'h00, 1'b1, 1'b1);
      send_fields(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      for (int i = 0; i < 5; i++)
         send_fields(8'h00, 8'h00, 8'h00, 8'hFF, 1'(i % 2 == 0), 1'b0);

      // low active limit, tiny ceiling, reload far above it
      apply_settings(10'd1023, 1'b0, 12'd2);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b1, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b1, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b0, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b1, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b0, 1'b1);
      send_fields(8'h00, 8'h00, 8'h01, 8'hFF, 1'b1, 1'b1);
      send_fields(8'h00, 8'h00, 8'h01, 8'hFF, 1'b0, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b1, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b0, 1'b1);
      send_fields(8'h00, 8'h00, 8'h03, 8'hFF, 1'b1, 1'b0);

      // random phases, each under its own register setting
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(10'd1023, 1'b0, 12'd2);
            1: apply_settings(10'd5, 1'b1, 12'd0);
            2: apply_settings(10'd1023, 1'b1, 12'd4095);
            3: apply_settings(10'd0, 1'b0, 12'd4095);
            default: begin
               apply_settings(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 40))
                                                          : 12'($urandom_range(0, 4095)));
            end
         endcase
         if (phase == 5) idle_on = 1'b0;
         for (int n = 0; n < 100; n++)
            send_tick(next_random_tick());
      end

      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d ticks under %0d register settings, %0d results checked.",
               sent_ticks, settings_used, board.checked);
      $display("Walk limit reloads: %0d, up edges held at the ceiling: %0d.",
               board.reloads, board.ceiling_hits);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Stop a run that hangs
   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_channels.sv
hw/rtl/lsc_run_filter.sv
hw/rtl/lsc_walk_counter.sv
hw/rtl/limit_switch_conditioner.sv
tb/sv/tb.sv
